>>> sv/bsf_pkg.sv
package bsf_pkg;

	// Field widths
	localparam int XW    = 9;
	localparam int ROWW  = 8;
	localparam int RBW   = 7;
	localparam int ADDRW = 14;
	localparam int MASKW = 8;
	localparam int COLW  = XW - 3;

	// Bitmap limits
	localparam int MAX_ROW_BYTES = 64;
	localparam int MAX_ROWS      = 256;
	localparam logic [RBW-1:0] ROW_BYTES_RST = RBW'(64);

	localparam logic [MASKW-1:0] FULL_MASK = 8'hFF;

	// Stream packing
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	typedef struct packed {
		logic load;   // capture a new span
		logic calc;   // compute base address and error
		logic step;   // advance to the next column byte
	} bsf_cmd_t;

	typedef struct packed {
		logic last;   // current request is the final one of the span
	} bsf_status_t;

endpackage

>>> sv/bsf_datapath.sv
module bsf_datapath #(
	parameter int MAX_ROW_BYTES = bsf_pkg::MAX_ROW_BYTES,
	parameter int MAX_ROWS      = bsf_pkg::MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [bsf_pkg::RBW-1:0]       cfg_wdata,
	input  bsf_pkg::bsf_cmd_t             cmd,
	output bsf_pkg::bsf_status_t          status,
	input  logic [bsf_pkg::XW-1:0]        x_start,
	input  logic [bsf_pkg::XW-1:0]        x_end,
	input  logic [bsf_pkg::ROWW-1:0]      row,
	output logic [bsf_pkg::ADDRW-1:0]     byte_address,
	output logic [bsf_pkg::MASKW-1:0]     or_mask,
	output logic                          last_write,
	output logic                          span_error
);

	logic [bsf_pkg::RBW-1:0]   row_bytes_q;
	logic [bsf_pkg::XW-1:0]    xs_q;
	logic [bsf_pkg::XW-1:0]    xe_q;
	logic [bsf_pkg::ROWW-1:0]  row_q;
	logic [bsf_pkg::RBW-1:0]   rb_q;
	logic [bsf_pkg::ADDRW-1:0] base_q;
	logic                      err_q;
	logic [bsf_pkg::COLW-1:0]  col_q;

	logic [bsf_pkg::RBW-1:0]   rb_clamp;
	logic [3:0]                last_sh;
	logic [bsf_pkg::MASKW-1:0] first_mask;
	logic [bsf_pkg::MASKW-1:0] last_mask;
	logic                      at_first;
	logic                      at_last;
	logic                      bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= bsf_pkg::ROW_BYTES_RST;
		end else if (cfg_wen) begin
			row_bytes_q <= cfg_wdata;
		end
	end

	assign rb_clamp = (row_bytes_q > bsf_pkg::RBW'(MAX_ROW_BYTES)) ?
			bsf_pkg::RBW'(MAX_ROW_BYTES) : row_bytes_q;

	// xe >= rb*8 is the same as xe's byte index >= rb
	assign bad = (xs_q > xe_q)
			|| ({1'b0, xe_q[bsf_pkg::XW-1:3]} >= rb_q)
			|| ({5'd0, row_q} >= 13'(MAX_ROWS));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xs_q  <= x_start;
			xe_q  <= x_end;
			row_q <= row;
			rb_q  <= rb_clamp;
		end
		if (cmd.calc) begin
			base_q <= bsf_pkg::ADDRW'(row_q * rb_q);
			err_q  <= bad;
			col_q  <= xs_q[bsf_pkg::XW-1:3];
		end else if (cmd.step) begin
			col_q  <= col_q + bsf_pkg::COLW'(1);
		end
	end

	assign last_sh    = {1'b0, xe_q[2:0]} + 4'd1;
	assign first_mask = bsf_pkg::FULL_MASK >> xs_q[2:0];
	assign last_mask  = ~(bsf_pkg::FULL_MASK >> last_sh);
	assign at_first   = (col_q == xs_q[bsf_pkg::XW-1:3]);
	assign at_last    = (col_q == xe_q[bsf_pkg::XW-1:3]);

	always_comb begin
		if (err_q) begin
			byte_address = '0;
			or_mask      = '0;
		end else begin
			byte_address = bsf_pkg::ADDRW'(base_q + bsf_pkg::ADDRW'(col_q));
			or_mask      = bsf_pkg::FULL_MASK
					& (at_first ? first_mask : bsf_pkg::FULL_MASK)
					& (at_last ? last_mask : bsf_pkg::FULL_MASK);
		end
	end

	assign last_write  = err_q | at_last;
	assign span_error  = err_q;
	assign status.last = last_write;

endmodule

>>> sv/bsf_ctrl.sv
module bsf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bsf_pkg::bsf_status_t status,
	output bsf_pkg::bsf_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/bitmap_span_fill.sv
// Horizontal span fill for a 1 bpp bitmap (MSB of each byte = leftmost pixel).
// Each request on the slave stream is one span (x_start..x_end inclusive on
// one row); the block answers with one byte write request per covered byte,
// left to right: byte_address = row * row_bytes + x/8 and an OR mask with
// edge trimming on the first and last byte (both edges when the span sits in
// one byte). tlast marks the final write of the span. A span with start after
// end, an end at or past row_bytes*8 pixels, or a row index at or past
// MAX_ROWS yields one request with tuser=1, tlast=1, address and mask 0.
// row_bytes resets to 64 and is clamped to MAX_ROW_BYTES; write it only
// while idle.
// Flow: one span is handled at a time. After a span is taken it passes through
// the address multiply state (row * row_bytes), then emits one write per cycle
// while the master side is ready. The controller walks the column counter; the
// stream sides are not overlapped.
module bitmap_span_fill #(
	parameter int MAX_ROW_BYTES = bsf_pkg::MAX_ROW_BYTES,
	parameter int MAX_ROWS      = bsf_pkg::MAX_ROWS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// row_bytes register write
	input  logic                                cfg_wen,
	input  logic [bsf_pkg::RBW-1:0]             cfg_wdata,
	// span request in
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [8:0] x_start, [17:9] x_end, [25:18] row, [31:26] zero
	input  logic [bsf_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	// byte write request out
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [13:0] byte_address, [21:14] or_mask, [23:22] zero
	output logic [bsf_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	output logic                                m_axis_tlast,  // last_write
	output logic                                m_axis_tuser   // span_error
);

	bsf_pkg::bsf_cmd_t         cmd;
	bsf_pkg::bsf_status_t      status;
	logic [bsf_pkg::ADDRW-1:0] byte_address;
	logic [bsf_pkg::MASKW-1:0] or_mask;

	bsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	bsf_datapath #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.MAX_ROWS      (MAX_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.status       (status),
		.x_start      (s_axis_tdata[8:0]),
		.x_end        (s_axis_tdata[17:9]),
		.row          (s_axis_tdata[25:18]),
		.byte_address (byte_address),
		.or_mask      (or_mask),
		.last_write   (m_axis_tlast),
		.span_error   (m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, or_mask, byte_address};

endmodule

>>> sv/bsf_checker.sv
module bsf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [bsf_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast,
	input logic                          m_axis_tuser
);

	// held request stays put while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("output request changed while stalled");

	// error request is a single, empty, final request
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("malformed error request");

	// a good span never writes an empty mask
	a_mask_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[21:14] != 8'd0))
		else $error("empty OR mask on a write");

	// no new span while writes of the current one are pending
	a_one_span: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("span taken while writes pending");

	// address multiply state separates a span from its first write
	a_calc_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("write issued in the cycle after span accept");

endmodule

bind bitmap_span_fill bsf_checker u_bsf_checker (.*);

>>> tb/tb_bitmap_span_fill.sv
`timescale 1ns / 1ps

module tb_bitmap_span_fill;

	// One span request: inclusive pixel columns on one bitmap row
	typedef struct packed {
		logic [bsf_pkg::XW-1:0]   xs;
		logic [bsf_pkg::XW-1:0]   xe;
		logic [bsf_pkg::ROWW-1:0] row;
	} span_t;

	// One byte write request as the block should emit it
	typedef struct packed {
		logic [bsf_pkg::ADDRW-1:0] addr;
		logic [bsf_pkg::MASKW-1:0] mask;
		logic                      last;
		logic                      err;
	} byte_write_t;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          cfg_wen       = 1'b0;
	logic [bsf_pkg::RBW-1:0]       cfg_wdata     = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	// [8:0] x_start, [17:9] x_end, [25:18] row, [31:26] zero
	logic [bsf_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	// [13:0] byte_address, [21:14] or_mask, [23:22] zero
	logic [bsf_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                          m_axis_tlast;   // last_write
	logic                          m_axis_tuser;   // span_error

	span_t       pending_spans[$];     // spans not yet offered to the block
	byte_write_t expected_writes[$];   // byte writes owed by accepted spans

	logic [bsf_pkg::RBW-1:0] row_bytes_shadow = bsf_pkg::ROW_BYTES_RST;
	bit  idle_en = 1'b1;     // random gaps on both streams
	int  src_gap;
	int  sink_gap;
	int  spans_taken;
	int  writes_checked;
	int  error_results;
	int  mismatches;
	int  settings_used;

	bitmap_span_fill dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Register above the row limit behaves as the limit
	function automatic int eff_row_bytes();
		return (row_bytes_shadow > bsf_pkg::MAX_ROW_BYTES) ?
			bsf_pkg::MAX_ROW_BYTES : int'(row_bytes_shadow);
	endfunction

	// Turn one span into its byte writes, left to right, and queue them
	function automatic void predict_span_writes(input span_t sp);
		byte_write_t w;
		int          rb;
		int          first_col;
		int          last_col;
		logic [bsf_pkg::MASKW-1:0] head_mask;
		logic [bsf_pkg::MASKW-1:0] tail_mask;
		rb = eff_row_bytes();
		if (sp.xs > sp.xe || int'(sp.xe) >= rb * 8 ||
			int'(sp.row) >= bsf_pkg::MAX_ROWS) begin
			// rejected span: one flagged request, nothing to write
			w = '{addr: '0, mask: '0, last: 1'b1, err: 1'b1};
			expected_writes.push_back(w);
			return;
		end
		first_col = sp.xs >> 3;
		last_col  = sp.xe >> 3;
		head_mask = bsf_pkg::FULL_MASK >> sp.xs[2:0];
		// a shift by 8 clears everything, leaving a full byte after inversion
		tail_mask = ~(bsf_pkg::FULL_MASK >> (int'(sp.xe[2:0]) + 1));
		for (int c = first_col; c <= last_col; c++) begin
			w.mask = bsf_pkg::FULL_MASK;
			if (c == first_col)
				w.mask &= head_mask;
			if (c == last_col)
				w.mask &= tail_mask;
			w.addr = bsf_pkg::ADDRW'(int'(sp.row) * rb + c);
			w.last = (c == last_col);
			w.err  = 1'b0;
			expected_writes.push_back(w);
		end
	endfunction

	// Random span, mostly legal for the current row width
	function automatic span_t pick_span();
		span_t sp;
		int    width;
		int    kind;
		int    hi;
		width  = eff_row_bytes() * 8;
		sp.row = bsf_pkg::ROWW'($urandom_range(0, 255));
		kind   = $urandom_range(0, 9);
		if (width == 0 || kind == 0) begin
			// raw noise
			sp.xs = bsf_pkg::XW'($urandom);
			sp.xe = bsf_pkg::XW'($urandom);
		end else if (kind == 1) begin
			// start after end
			sp.xe = bsf_pkg::XW'($urandom_range(0, 510));
			sp.xs = bsf_pkg::XW'($urandom_range(int'(sp.xe) + 1, 511));
		end else if (kind == 2 && width < 512) begin
			// end past the row
			sp.xe = bsf_pkg::XW'($urandom_range(width, 511));
			sp.xs = bsf_pkg::XW'($urandom_range(0, int'(sp.xe)));
		end else if (kind <= 5) begin
			// short span, often inside one or two bytes
			sp.xs = bsf_pkg::XW'($urandom_range(0, width - 1));
			hi    = int'(sp.xs) + $urandom_range(0, 15);
			sp.xe = bsf_pkg::XW'((hi > width - 1) ? width - 1 : hi);
		end else begin
			sp.xe = bsf_pkg::XW'($urandom_range(0, width - 1));
			sp.xs = bsf_pkg::XW'($urandom_range(0, int'(sp.xe)));
		end
		return sp;
	endfunction

	// Span source: one request in flight, random gaps between requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				span_t acc;
				acc.xs  = s_axis_tdata[bsf_pkg::XW-1:0];
				acc.xe  = s_axis_tdata[2*bsf_pkg::XW-1:bsf_pkg::XW];
				acc.row = s_axis_tdata[2*bsf_pkg::XW+bsf_pkg::ROWW-1:2*bsf_pkg::XW];
				predict_span_writes(acc);
				spans_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_spans.size() != 0 &&
					idle_en && $urandom_range(0, 3) == 0) begin
					src_gap = $urandom_range(1, 16) - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_spans.size() != 0) begin
					span_t sp;
					sp = pending_spans.pop_front();
					s_axis_tdata  <= bsf_pkg::S_TDATA_W'({sp.row, sp.xe, sp.xs});
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Write sink: random back-pressure, compare each write with the oldest owed one
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				byte_write_t got;
				byte_write_t want;
				got = '{addr: m_axis_tdata[bsf_pkg::ADDRW-1:0],
					mask: m_axis_tdata[bsf_pkg::ADDRW+bsf_pkg::MASKW-1:bsf_pkg::ADDRW],
					last: m_axis_tlast, err: m_axis_tuser};
				if (got.err)
					error_results++;
				if (expected_writes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected write addr=%h mask=%h last=%b err=%b",
						$time, got.addr, got.mask, got.last, got.err);
				end else begin
					want = expected_writes.pop_front();
					writes_checked++;
					if (got.addr !== want.addr || got.mask !== want.mask ||
						got.last !== want.last || got.err !== want.err) begin
						mismatches++;
						$display("%0t: expected addr=%h mask=%h last=%b err=%b, %s",
							$time, want.addr, want.mask, want.last, want.err,
							$sformatf("got addr=%h mask=%h last=%b err=%b",
								got.addr, got.mask, got.last, got.err));
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(1, 16) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Register write, only called with both streams quiet
	task automatic set_row_bytes(input logic [bsf_pkg::RBW-1:0] value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		row_bytes_shadow = value;
		settings_used++;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Wait for every queued span to be taken and every owed write to arrive
	task automatic drain();
		while (pending_spans.size() != 0 || s_axis_tvalid || expected_writes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_span(input int xs, input int xe, input int row);
		pending_spans.push_back('{xs: bsf_pkg::XW'(xs), xe: bsf_pkg::XW'(xe),
			row: bsf_pkg::ROWW'(row)});
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset width (64 bytes per row)
		queue_span(0, 511, 255);    // whole row, top address
		queue_span(0, 0, 0);        // first pixel
		queue_span(7, 7, 0);        // last pixel of a byte
		queue_span(3, 5, 10);       // both edges in one byte
		queue_span(0, 7, 1);        // exactly one full byte
		queue_span(5, 8, 2);        // last byte at offset zero
		queue_span(8, 8, 3);        // lone pixel at offset zero
		queue_span(1, 22, 4);       // head, full, tail
		queue_span(511, 511, 255);  // far right pixel
		queue_span(9, 8, 5);        // start after end
		queue_span(511, 0, 6);      // start after end, far apart
		queue_span(256, 300, 128);
		drain();

		// One byte per row
		set_row_bytes(bsf_pkg::RBW'(1));
		queue_span(0, 7, 255);
		queue_span(0, 8, 0);        // end past row width
		queue_span(3, 3, 7);
		drain();

		// Empty row: every span rejected
		set_row_bytes(bsf_pkg::RBW'(0));
		queue_span(0, 0, 0);
		queue_span(0, 511, 9);
		drain();

		// Register above the limit, treated as 64
		set_row_bytes(bsf_pkg::RBW'(127));
		queue_span(0, 511, 17);
		queue_span(500, 511, 200);
		queue_span(0, 511, 255);
		drain();

		// Random phases over several widths; the final one runs without gaps
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_row_bytes(bsf_pkg::RBW'(64));
				1: set_row_bytes(bsf_pkg::RBW'(1));
				2: set_row_bytes(bsf_pkg::RBW'($urandom_range(2, 63)));
				3: set_row_bytes(bsf_pkg::RBW'($urandom_range(65, 127)));
				4: set_row_bytes(bsf_pkg::RBW'($urandom_range(0, 127)));
				default: begin
					idle_en = 1'b0;
					set_row_bytes(bsf_pkg::RBW'($urandom_range(1, 64)));
				end
			endcase
			for (int i = 0; i < 15; i++)
				pending_spans.push_back(pick_span());
			drain();
		end

		repeat (80) @(posedge clk);
		$display("Spans accepted: %0d over %0d row width settings", spans_taken, settings_used);
		$display("Byte writes checked: %0d, rejected spans seen: %0d, mismatches: %0d",
			writes_checked, error_results, mismatches);
		if (mismatches == 0 && expected_writes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d writes still owed", expected_writes.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
